// File: src/pse_pkg.sv
// Shared types, status codes and helpers for the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

	localparam int DEF_STACK_DEPTH = 128;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [1:0] TOK_NUMBER = 2'd0;
	localparam logic [1:0] TOK_OPER   = 2'd1;
	localparam logic [1:0] TOK_END    = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FEW      = 3'd1;
	localparam logic [2:0] ST_DIV0     = 3'd2;
	localparam logic [2:0] ST_ILLEGAL  = 3'd3;
	localparam logic [2:0] ST_MANY     = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] number_value;
		logic [7:0]         operator_char;
	} token_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
	} result_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} alu_op_t;

	// Controller to datapath.
	typedef struct packed {
		logic    push_in;     // write the token number at count
		logic    rd_right;    // read entry count-1
		logic    rd_left;     // read entry count-2
		logic    cap_right;   // capture read data as right operand
		logic    cap_left;    // capture read data as left operand
		logic    start;       // start the arithmetic on the captured operands
		alu_op_t op;
		logic    push_res;    // write the arithmetic result at count
		logic    rd_bottom;   // read entry zero
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic right_zero;
		logic alu_done;
	} dp_status_t;

	// Saturate a sign and a magnitude to the signed 32-bit range.
	function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (mag >= 64'h8000_0000) r = 32'h8000_0000;
			else r = 32'(~mag[31:0] + 32'd1);
		end else begin
			if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = mag[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/pse_datapath.sv
// Datapath: operand stack memory, operand registers, adder and iterative mul/div unit.
`timescale 1ns / 1ps
module pse_datapath #(
	parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
	parameter int FRAC_BITS   = pse_pkg::DEF_FRAC_BITS,
	parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pse_pkg::dp_cmd_t     cmd,
	input  logic [CW-1:0]        count,
	input  logic [31:0]          in_value,
	output pse_pkg::dp_status_t  stat,
	output logic [31:0]          rd_data,
	output logic [31:0]          alu_res
);
	import pse_pkg::*;

	localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int NW   = 32 + FRAC_BITS;          // dividend width
	localparam int ITW  = $clog2(NW + 1);

	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] right_q, left_q;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW-1:0] cm1, cm2;

	assign cm1 = count - CW'(1);
	assign cm2 = count - CW'(2);
	assign wr_addr = count[AW-1:0];
	always_comb begin
		priority if (cmd.rd_right) rd_addr = cm1[AW-1:0];
		else if (cmd.rd_left) rd_addr = cm2[AW-1:0];
		else rd_addr = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push_in) mem[wr_addr] <= in_value;
		else if (cmd.push_res) mem[wr_addr] <= alu_res;
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_right) right_q <= rd_data;
		if (cmd.cap_left) left_q <= rd_data;
	end

	assign stat.right_zero = (right_q == 32'd0);

	// Iterative unit: shift-add multiply or restoring divide, one bit a cycle.
	logic        busy_q, done_q, neg_q;
	alu_op_t     op_q;
	logic [ITW-1:0] iter_q;
	logic [63:0] acc_q;        // product or quotient
	logic [NW-1:0] num_q;      // dividend bits shifting out
	logic [32:0] rem_q;
	logic [31:0] mb_q;         // magnitude of the right operand
	logic [31:0] ma_q;         // multiplier bits of the left magnitude
	logic [31:0] res_q;

	logic [31:0] mag_l, mag_r;
	logic [32:0] rem_sh;
	logic [63:0] mul_sum;
	logic signed [32:0] addsub;
	assign mag_l = left_q[31]  ? (~left_q + 32'd1)  : left_q;
	assign mag_r = right_q[31] ? (~right_q + 32'd1) : right_q;
	assign rem_sh = {rem_q[31:0], num_q[NW-1]};
	assign mul_sum = {acc_q[62:0], 1'b0} + (ma_q[31] ? {32'd0, mb_q} : 64'd0);

	always_comb begin
		addsub = (cmd.op == OP_SUB) ? ($signed({left_q[31], left_q}) - $signed({right_q[31], right_q}))
		                            : ($signed({left_q[31], left_q}) + $signed({right_q[31], right_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && (cmd.op == OP_ADD || cmd.op == OP_SUB)) begin
				done_q <= 1'b1;
			end else if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && iter_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			neg_q <= left_q[31] ^ right_q[31];
			mb_q  <= mag_r;
			ma_q  <= mag_l;
			num_q <= NW'({mag_l, {FRAC_BITS{1'b0}}});
			rem_q <= '0;
			acc_q <= '0;
			iter_q <= (cmd.op == OP_MUL) ? ITW'(32) : ITW'(NW);
			if (addsub > 33'sh0_7FFF_FFFF) res_q <= 32'h7FFF_FFFF;
			else if (addsub < -33'sh0_8000_0000) res_q <= 32'h8000_0000;
			else res_q <= addsub[31:0];
		end else if (busy_q && iter_q != '0) begin
			iter_q <= iter_q - ITW'(1);
			if (op_q == OP_MUL) begin
				acc_q <= mul_sum;
				ma_q  <= {ma_q[30:0], 1'b0};
			end else begin
				num_q <= {num_q[NW-2:0], 1'b0};
				if (rem_sh >= {1'b0, mb_q}) begin
					rem_q <= rem_sh - {1'b0, mb_q};
					acc_q <= {acc_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					acc_q <= {acc_q[62:0], 1'b0};
				end
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) res_q <= sat_mag(neg_q, acc_q >> FRAC_BITS);
			else res_q <= sat_mag(neg_q, acc_q);
		end
	end

	assign stat.alu_done = done_q;
	assign alu_res = res_q;

endmodule

// File: src/pse_ctrl.sv
// Controller: token sequencing, stack count, error latch and result register.
`timescale 1ns / 1ps
module pse_ctrl #(
	parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
	parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pse_pkg::token_t     tok,
	input  logic                tok_valid,
	output logic                tok_stall,
	output pse_pkg::result_t    res,
	output logic                res_valid,
	input  logic                res_stall,
	output pse_pkg::dp_cmd_t    cmd,
	output logic [CW-1:0]       count,
	input  pse_pkg::dp_status_t stat,
	input  logic [31:0]         rd_data
);
	import pse_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RDR   = 7'b0000010,
		S_RDL   = 7'b0000100,
		S_CAPL  = 7'b0001000,
		S_ALU   = 7'b0010000,
		S_WAIT  = 7'b0100000,
		S_END   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [2:0] err_q;
	alu_op_t op_q;
	logic illegal_q;
	logic accept;

	assign count = count_q;
	assign tok_stall = (state_q != S_IDLE) || res_valid;
	assign accept = tok_valid && !tok_stall;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.push_in = accept && tok.req_type == TOK_NUMBER && err_q == ST_OK
		              && count_q < CW'(STACK_DEPTH);
		cmd.rd_right = accept && tok.req_type == TOK_OPER && err_q == ST_OK;
		cmd.rd_bottom = accept && tok.req_type == TOK_END;
		cmd.cap_right = (state_q == S_RDR);
		// The left address is held so that the read data is still valid when it is captured.
		cmd.rd_left = (state_q == S_RDR) || (state_q == S_RDL);
		cmd.cap_left = (state_q == S_CAPL);
		cmd.start = (state_q == S_ALU) && !(op_q == OP_DIV && stat.right_zero);
		cmd.push_res = (state_q == S_WAIT) && stat.alu_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q <= ST_OK;
			res_valid <= 1'b0;
			op_q <= OP_ADD;
			illegal_q <= 1'b0;
		end else begin
			if (res_valid && !res_stall) res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (tok.req_type)
							TOK_NUMBER: begin
								if (err_q == ST_OK) begin
									if (count_q < CW'(STACK_DEPTH)) count_q <= count_q + CW'(1);
									else err_q <= ST_OVERFLOW;
								end
							end
							TOK_OPER: begin
								if (err_q == ST_OK) begin
									if (count_q < CW'(2)) begin
										count_q <= '0;
										err_q <= ST_FEW;
									end else begin
										illegal_q <= 1'b0;
										unique case (tok.operator_char)
											CH_PLUS:  op_q <= OP_ADD;
											CH_MINUS: op_q <= OP_SUB;
											CH_STAR:  op_q <= OP_MUL;
											CH_SLASH: op_q <= OP_DIV;
											default:  illegal_q <= 1'b1;
										endcase
										state_q <= S_RDR;
									end
								end
							end
							TOK_END: state_q <= S_END;
							default: ;
						endcase
					end
				end
				S_RDR: state_q <= S_RDL;
				S_RDL: state_q <= S_CAPL;
				S_CAPL: begin
					count_q <= count_q - CW'(2);
					if (illegal_q) begin
						err_q <= ST_ILLEGAL;
						state_q <= S_IDLE;
					end else state_q <= S_ALU;
				end
				S_ALU: begin
					// Right operand was captured in S_RDR.
					if (op_q == OP_DIV && stat.right_zero) begin
						err_q <= ST_DIV0;
						state_q <= S_IDLE;
					end else state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (stat.alu_done) begin
						count_q <= count_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_END: begin
					res_valid <= 1'b1;
					count_q <= '0;
					err_q <= ST_OK;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_END) begin
			if (err_q != ST_OK) begin
				res.status <= err_q;
				res.result_value <= '0;
			end else if (count_q == '0) begin
				res.status <= ST_EMPTY;
				res.result_value <= '0;
			end else if (count_q > CW'(1)) begin
				res.status <= ST_MANY;
				res.result_value <= '0;
			end else begin
				res.status <= ST_OK;
				res.result_value <= rd_data;
			end
		end
	end

endmodule

// File: src/postfix_stack_evaluator.sv
// + and - use the saturating adder; * runs in the iterative unit, and / produces
// 32 + FRAC_BITS quotient bits, one per cycle in the shared shift-add/subtract unit.
// An end token moves to S_END, which registers the result and its valid; requests are taken one at a time.
// Reset clears the stack count, error latch and result valid; stack memory is not cleared.
`timescale 1ns / 1ps
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
	parameter int FRAC_BITS   = pse_pkg::DEF_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pse_pkg::token_t  in_data,
	input  logic             in_valid,
	output logic             in_stall,
	output pse_pkg::result_t out_data,
	output logic             out_valid,
	input  logic             out_stall
);
	import pse_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	dp_cmd_t    cmd;
	dp_status_t stat;
	logic [CW-1:0] count;
	logic [31:0] rd_data, alu_res;

	pse_ctrl #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_ctrl (
		.clk, .arst_n, .tok(in_data), .tok_valid(in_valid), .tok_stall(in_stall),
		.res(out_data), .res_valid(out_valid), .res_stall(out_stall),
		.cmd, .count, .stat, .rd_data
	);

	pse_datapath #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_dp (
		.clk, .arst_n, .cmd, .count, .in_value(in_data.number_value), .stat,
		.rd_data, .alu_res
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
	a_no_double_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push_in && cmd.push_res)) else $error("two stack writes in one cycle");
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.req_type == TOK_END) |=> ##1 out_valid)
		else $error("end request produced no result");
	a_result_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> out_data.result_value == '0)
		else $error("error result carries a value");

endmodule

// File: tb/sv/tb.sv
// Testbench for the postfix stack evaluator: random and directed token streams checked against a model.
`timescale 1ns / 1ps
module tb;
	import pse_pkg::*;

	localparam int DEPTH = DEF_STACK_DEPTH;
	localparam int FRAC = DEF_FRAC_BITS;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	token_t in_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	result_t out_data;
	logic out_valid;
	logic out_stall = 1'b0;

	postfix_stack_evaluator dut (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_valid(in_valid),
		.in_stall(in_stall), .out_data(out_data), .out_valid(out_valid),
		.out_stall(out_stall)
	);

	logic [31:0] eval_stack[DEPTH];
	int eval_count = 0;
	logic [2:0] eval_error = ST_OK;
	result_t pending_results[$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	longint cycle_count = 0;
	int depth_now = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [31:0] clamp_mag(input logic neg, input logic [63:0] mag);
		if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	function automatic logic [31:0] clamp_sum(input longint s);
		if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (s < -64'sh8000_0000) return 32'h8000_0000;
		return s[31:0];
	endfunction

	// Applies one token to the local evaluator and queues the result of an end token.
	task automatic evaluate_token(input token_t t);
		logic [31:0] l, r, res;
		logic [63:0] ml, mr;
		logic neg;
		result_t rs;
		if (t.req_type == TOK_NUMBER) begin
			if (eval_error != ST_OK) return;
			if (eval_count >= DEPTH) begin
				eval_error = ST_OVERFLOW;
				return;
			end
			eval_stack[eval_count] = t.number_value;
			eval_count++;
		end else if (t.req_type == TOK_OPER) begin
			if (eval_error != ST_OK) return;
			if (eval_count < 2) begin
				eval_count = 0;
				eval_error = ST_FEW;
				return;
			end
			r = eval_stack[eval_count - 1];
			l = eval_stack[eval_count - 2];
			eval_count -= 2;
			neg = l[31] ^ r[31];
			ml = l[31] ? 64'(32'(-l)) : 64'(l);
			mr = r[31] ? 64'(32'(-r)) : 64'(r);
			case (t.operator_char)
				CH_PLUS: res = clamp_sum(longint'($signed(l)) + longint'($signed(r)));
				CH_MINUS: res = clamp_sum(longint'($signed(l)) - longint'($signed(r)));
				CH_STAR: res = clamp_mag(neg, (ml * mr) >> FRAC);
				CH_SLASH: begin
					if (r == 0) begin
						eval_error = ST_DIV0;
						return;
					end
					res = clamp_mag(neg, (ml << FRAC) / mr);
				end
				default: begin
					eval_error = ST_ILLEGAL;
					return;
				end
			endcase
			eval_stack[eval_count] = res;
			eval_count++;
		end else if (t.req_type == TOK_END) begin
			rs.result_value = 0;
			if (eval_error != ST_OK) rs.status = eval_error;
			else if (eval_count == 0) rs.status = ST_EMPTY;
			else if (eval_count > 1) rs.status = ST_MANY;
			else begin
				rs.status = ST_OK;
				rs.result_value = eval_stack[0];
			end
			pending_results.push_back(rs);
			eval_count = 0;
			eval_error = ST_OK;
		end
	endtask

	// Sends one request and keeps valid high while the block stalls. Valid stays high after
	// acceptance until the next request or an idle cycle replaces it.
	task automatic send_token(input token_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		evaluate_token(t);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: value %h status %0d",
					out_data.result_value, out_data.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.result_value !== want.result_value) begin
					$error("result_value expected %h actual %h", want.result_value,
						out_data.result_value);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, out_data.status);
					fail_count++;
				end
			end
		end
	end

	function automatic token_t make_num(input logic [31:0] v);
		token_t t;
		t = '0;
		t.req_type = TOK_NUMBER;
		t.number_value = v;
		t.operator_char = 8'($urandom);
		return t;
	endfunction

	function automatic token_t make_op(input logic [7:0] c);
		token_t t;
		t.req_type = TOK_OPER;
		t.number_value = $urandom;
		t.operator_char = c;
		return t;
	endfunction

	function automatic token_t make_end();
		token_t t;
		t.req_type = TOK_END;
		t.number_value = $urandom;
		t.operator_char = 8'($urandom);
		return t;
	endfunction

	function automatic logic [7:0] legal_op();
		case ($urandom_range(3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// Operands that mix extremes, small values and full random words.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(8)) - 4) << FRAC;
			3: return 32'(int'($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_binary(input logic [31:0] a, input logic [31:0] b,
			input logic [7:0] c);
		send_token(make_num(a));
		send_token(make_num(b));
		send_token(make_op(c));
		send_token(make_end());
	endtask

	task automatic test_directed();
		token_t t;
		send_binary(32'h7FFF_FFFF, 32'h0000_0001, CH_PLUS);
		send_binary(32'h8000_0000, 32'h0000_0001, CH_MINUS);
		send_binary(32'h8000_0000, 32'hFFFF_FFFF, CH_STAR);
		send_binary(32'h0003_0000, 32'hFFFE_0000, CH_SLASH);
		send_binary(32'h0001_0000, 32'h0000_0000, CH_SLASH);
		send_binary(32'h0001_0000, 32'h0002_0000, "#");
		send_token(make_op(CH_PLUS));
		send_token(make_end());
		send_token(make_end());
		t = make_end();
		t.req_type = 2'd3;
		send_token(t);
		send_token(make_num(32'h1));
		send_token(make_num(32'h2));
		send_token(make_end());
	endtask

	task automatic test_overflow();
		for (int i = 0; i <= DEPTH; i++) send_token(make_num(pick_value()));
		send_token(make_op(CH_PLUS));
		send_token(make_end());
		for (int i = 0; i < DEPTH; i++) send_token(make_num(i));
		send_token(make_end());
	endtask

	// Well-formed expressions with random content, with some broken ones and noise.
	task automatic test_random(input int n_tokens);
		int sent;
		token_t t;
		sent = 0;
		while (sent < n_tokens) begin
			if ($urandom_range(9) < 8) begin
				depth_now = 0;
				repeat ($urandom_range(6) + 1) begin
					send_token(make_num(pick_value()));
					depth_now++;
					sent++;
					while (depth_now >= 2 && $urandom_range(1)) begin
						send_token(make_op(legal_op()));
						depth_now--;
						sent++;
					end
				end
				while (depth_now >= 2) begin
					send_token(make_op(legal_op()));
					depth_now--;
					sent++;
				end
			end else begin
				repeat ($urandom_range(5)) begin
					t.req_type = 2'($urandom);
					t.number_value = $urandom;
					t.operator_char = $urandom_range(3) == 0 ? 8'($urandom) : legal_op();
					if (t.req_type != TOK_END) send_token(t);
					sent++;
				end
			end
			send_token(make_end());
			sent++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		send_idle_pct = 0; stall_pct = 0;
		test_random(250);
		wait_drained();
		send_idle_pct = 45; stall_pct = 0;
		test_random(250);
		send_idle_pct = 0; stall_pct = 45;
		test_random(250);
		send_idle_pct = 32; stall_pct = 32;
		test_random(250);
		wait_drained();
		stall_pct = 0;
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
